// ===== rtl/core/fbrd_pkg.sv =====
// shared types and constants of the framebuffer line and rectangle drawer
// no dependencies; imported by fbrd_frame_mem, framebuffer_line_rect_drawer_top and the testbench
package fbrd_pkg;

	// frame geometry and pixel depth
	localparam int FRAME_WIDTH  = 64;
	localparam int FRAME_HEIGHT = 32;
	localparam int COLOR_BITS   = 4;

	localparam int PIX_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W    = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;

	// command codes
	localparam logic [2:0] OP_SET_PEN = 3'd0;
	localparam logic [2:0] OP_CLEAR   = 3'd1;
	localparam logic [2:0] OP_PIXEL   = 3'd2;
	localparam logic [2:0] OP_HLINE   = 3'd3;
	localparam logic [2:0] OP_VLINE   = 3'd4;
	localparam logic [2:0] OP_RECT    = 3'd5;
	localparam logic [2:0] OP_READ    = 3'd6;

	// one command item
	typedef struct packed {
		logic [2:0] operation;
		logic [5:0] x_start;
		logic [4:0] y_start;
		logic [6:0] x_end;
		logic [5:0] y_end;
		logic [3:0] color_in;
	} fbrd_cmd_t;

	// one result item
	typedef struct packed {
		logic [3:0] read_color;
		logic       out_of_range;
	} fbrd_res_t;

	// frame store write port
	typedef struct packed {
		logic                  en;
		logic [ADDR_W-1:0]     addr;
		logic [COLOR_BITS-1:0] data;
	} fbrd_wr_t;

	// frame store read port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} fbrd_rd_t;

endpackage

// ===== rtl/core/framebuffer_line_rect_drawer_top.sv =====
// top level of the framebuffer line and rectangle drawer: command sequencer
// depends on fbrd_pkg and fbrd_frame_mem
//
// Usage: command items arrive on cmd (valid/ready), one result item per
// command leaves on res (valid/ready). cmd_ready is high only while the
// sequencer is idle; one command is worked on at a time.
// Steps from acceptance to the result register (the frame store writes one
// pixel per cycle while a segment is drawn or the store is cleared):
//   set pen, unused code: straight to posting
//   read: a store read if the point is in range, then registered read data
//   pixel, hline, vline: a segment load, then one write per pixel of the line
//     (an empty line: the load only)
//   rectangle: a load and the pixels of each of the five segments in turn
//   clear: a sweep of the whole store, one pixel a cycle
// The result is visible on res the cycle after it is posted.
// After reset the store is swept to black, all PIX_COUNT pixels (2048 here),
// with cmd_ready low; no result item comes from that sweep.
// The result register decouples the sides: a new command is taken while a
// result still waits; if the receiver stalls, a finished command waits in
// its posting state until the register is free.
module framebuffer_line_rect_drawer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  fbrd_pkg::fbrd_cmd_t cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output fbrd_pkg::fbrd_res_t res
);
	import fbrd_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CLEAR = 6'b000010,
		S_LOAD  = 6'b000100,
		S_RUN   = 6'b001000,
		S_READ  = 6'b010000,
		S_POST  = 6'b100000
	} state_t;

	state_t                state_q;
	fbrd_cmd_t             cmd_q;
	logic [COLOR_BITS-1:0] pen_q;
	logic                  flag_q;
	logic                  post_clear_q;
	logic [ADDR_W-1:0]     clr_addr_q;
	logic [2:0]            seg_q;
	logic                  seg_horiz_q;
	logic [6:0]            seg_fix_q;
	logic [7:0]            seg_end_q;
	logic [7:0]            pos_q;
	logic                  res_valid_q;
	fbrd_res_t             res_q;

	fbrd_wr_t              wr;
	fbrd_rd_t              rd;
	logic [COLOR_BITS-1:0] rdata;

	logic                  cmd_fire;
	logic                  post_fire;
	logic                  seg_horiz;
	logic [6:0]            seg_fix;
	logic [7:0]            seg_start;
	logic [7:0]            seg_end;
	logic                  seg_last;
	logic [2:0]            seg_sel;
	logic [7:0]            px;
	logic [7:0]            py;
	logic                  px_in;
	logic [ADDR_W-1:0]     px_addr;
	logic                  rd_in;
	logic [ADDR_W-1:0]     rd_addr;
	fbrd_res_t             res_d;

	assign cmd_ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign post_fire = (state_q == S_POST) && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// segment table: hline uses the first row, vline the first column,
	// a single pixel is a one-wide row, rectangles walk the first five
	always_comb begin
		if (cmd_q.operation == OP_VLINE) begin
			seg_sel = 3'd2;
		end else if (cmd_q.operation == OP_PIXEL) begin
			seg_sel = 3'd5;
		end else begin
			seg_sel = seg_q;
		end
		seg_last = (cmd_q.operation == OP_RECT) ? (seg_q == 3'd4) : 1'b1;
		case (seg_sel)
			3'd0: begin
				seg_horiz = 1'b1;
				seg_fix   = 7'(cmd_q.y_start);
				seg_start = 8'(cmd_q.x_start);
				seg_end   = 8'(cmd_q.x_end);
			end
			3'd1: begin
				seg_horiz = 1'b1;
				seg_fix   = 7'(cmd_q.y_end);
				seg_start = 8'(cmd_q.x_start);
				seg_end   = 8'(cmd_q.x_end);
			end
			3'd2: begin
				seg_horiz = 1'b0;
				seg_fix   = 7'(cmd_q.x_start);
				seg_start = 8'(cmd_q.y_start);
				seg_end   = 8'(cmd_q.y_end);
			end
			3'd3: begin
				seg_horiz = 1'b0;
				seg_fix   = cmd_q.x_end;
				seg_start = 8'(cmd_q.y_start);
				seg_end   = 8'(cmd_q.y_end);
			end
			3'd4: begin
				seg_horiz = 1'b1;
				seg_fix   = 7'(cmd_q.y_end);
				seg_start = 8'(cmd_q.x_end);
				seg_end   = 8'(cmd_q.x_end) + 8'd1;
			end
			3'd5: begin
				seg_horiz = 1'b1;
				seg_fix   = 7'(cmd_q.y_start);
				seg_start = 8'(cmd_q.x_start);
				seg_end   = 8'(cmd_q.x_start) + 8'd1;
			end
			default: begin
				seg_horiz = 1'b1;
				seg_fix   = '0;
				seg_start = '0;
				seg_end   = '0;
			end
		endcase
	end

	// cursor position, range check and store address
	always_comb begin
		px      = seg_horiz_q ? pos_q : 8'(seg_fix_q);
		py      = seg_horiz_q ? 8'(seg_fix_q) : pos_q;
		px_in   = (32'(px) < FRAME_WIDTH) && (32'(py) < FRAME_HEIGHT);
		px_addr = ADDR_W'(32'(py) * FRAME_WIDTH + 32'(px));
		rd_in   = (32'(cmd_q.x_start) < FRAME_WIDTH) && (32'(cmd_q.y_start) < FRAME_HEIGHT);
		rd_addr = ADDR_W'(32'(cmd_q.y_start) * FRAME_WIDTH + 32'(cmd_q.x_start));
	end

	// store ports
	always_comb begin
		wr = '0;
		rd = '0;
		if (state_q == S_CLEAR) begin
			wr.en   = 1'b1;
			wr.addr = clr_addr_q;
			wr.data = '0;
		end else if (state_q == S_RUN) begin
			wr.en   = px_in;
			wr.addr = px_addr;
			wr.data = pen_q;
		end
		if (state_q == S_READ) begin
			rd.en   = rd_in;
			rd.addr = rd_addr;
		end
	end

	// result of the finished command
	always_comb begin
		res_d.out_of_range = flag_q;
		if (cmd_q.operation == OP_READ && !flag_q) begin
			res_d.read_color = 4'(rdata);
		end else begin
			res_d.read_color = '0;
		end
	end

	fbrd_frame_mem u_frame_mem (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

	// command capture and segment payload
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			cmd_q <= cmd;
		end
		if (state_q == S_LOAD) begin
			seg_horiz_q <= seg_horiz;
			seg_fix_q   <= seg_fix;
			seg_end_q   <= seg_end;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			pen_q        <= '0;
			flag_q       <= 1'b0;
			post_clear_q <= 1'b0;
			clr_addr_q   <= '0;
			seg_q        <= '0;
			pos_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						flag_q <= 1'b0;
						seg_q  <= '0;
						case (cmd.operation)
							OP_SET_PEN: begin
								pen_q   <= COLOR_BITS'(cmd.color_in);
								state_q <= S_POST;
							end
							OP_CLEAR: begin
								pen_q        <= '0;
								clr_addr_q   <= '0;
								post_clear_q <= 1'b1;
								state_q      <= S_CLEAR;
							end
							OP_PIXEL, OP_HLINE, OP_VLINE, OP_RECT: begin
								state_q <= S_LOAD;
							end
							OP_READ: begin
								state_q <= S_READ;
							end
							default: begin
								state_q <= S_POST;
							end
						endcase
					end
				end
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(PIX_COUNT - 1)) begin
						state_q <= post_clear_q ? S_POST : S_IDLE;
					end
				end
				S_LOAD: begin
					if (seg_end > seg_start) begin
						pos_q   <= seg_start;
						state_q <= S_RUN;
					end else if (seg_last) begin
						state_q <= S_POST;
					end else begin
						seg_q <= seg_q + 3'd1;
					end
				end
				S_RUN: begin
					if (!px_in) begin
						flag_q <= 1'b1;
					end
					pos_q <= pos_q + 8'd1;
					if (pos_q + 8'd1 == seg_end_q) begin
						if (seg_last) begin
							state_q <= S_POST;
						end else begin
							seg_q   <= seg_q + 3'd1;
							state_q <= S_LOAD;
						end
					end
				end
				S_READ: begin
					if (!rd_in) begin
						flag_q <= 1'b1;
					end
					state_q <= S_POST;
				end
				S_POST: begin
					if (post_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (post_fire) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (post_fire) begin
			res_q <= res_d;
		end
	end

	// an accepted command always leaves the idle state
	a_fire_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> state_q != S_IDLE)
		else $error("accepted command did not start");

	// the clear sweep writes black with the pen already black
	a_clear_black: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (wr.en && wr.data == '0 && pen_q == '0))
		else $error("clear sweep not writing black");

	// the cursor stays inside its segment while drawing
	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> pos_q < seg_end_q)
		else $error("cursor ran past segment end");

	// a posted result appears on the output the next cycle
	a_post_valid: assert property (@(posedge clk) disable iff (!arst_n)
		post_fire |=> res_valid)
		else $error("posted result not presented");

	// no store write outside the drawing and clearing states
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == S_CLEAR || state_q == S_RUN))
		else $error("stray frame store write");

endmodule

// ===== rtl/core/fbrd_frame_mem.sv =====
// frame store: one write port, one read port, registered read data
// depends on fbrd_pkg for geometry and port structs
module fbrd_frame_mem (
	input  logic                           clk,
	input  fbrd_pkg::fbrd_wr_t             wr,
	input  fbrd_pkg::fbrd_rd_t             rd,
	output logic [fbrd_pkg::COLOR_BITS-1:0] rdata
);
	import fbrd_pkg::*;

	logic [COLOR_BITS-1:0] mem [PIX_COUNT];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata <= mem[rd.addr];
		end
	end

endmodule

// ===== tb/sv/framebuffer_line_rect_drawer_top_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of framebuffer_line_rect_drawer_top: directed and random commands
// keeps its own copy of frame and pen to predict each result; depends on fbrd_pkg
module framebuffer_line_rect_drawer_top_tb;
	import fbrd_pkg::*;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int LONG_HOLD = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	fbrd_cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	fbrd_res_t res;

	framebuffer_line_rect_drawer_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// commands waiting to be offered, results still owed by the block
	fbrd_cmd_t cmd_backlog[$];
	fbrd_res_t results_due[$];
	int mismatch_count = 0;
	bit steady = 1'b0;
	bit hold_go = 1'b0;

	// shadow frame and pen
	logic [COLOR_BITS-1:0] frame_copy [PIX_COUNT];
	logic [COLOR_BITS-1:0] pen_copy;
	bit stray_pixel;

	function automatic void plot(int x, int y);
		if (x >= FRAME_WIDTH || y >= FRAME_HEIGHT) begin
			stray_pixel = 1'b1;
		end else begin
			frame_copy[y * FRAME_WIDTH + x] = pen_copy;
		end
	endfunction

	function automatic void plot_row(int x0, int y, int x1);
		for (int x = x0; x < x1; x++) plot(x, y);
	endfunction

	function automatic void plot_col(int x, int y0, int y1);
		for (int y = y0; y < y1; y++) plot(x, y);
	endfunction

	// update the shadow state with one command and return its result
	function automatic fbrd_res_t apply_command(fbrd_cmd_t c);
		fbrd_res_t r;
		int xs;
		int ys;
		int xe;
		int ye;
		r = '0;
		stray_pixel = 1'b0;
		xs = int'(c.x_start);
		ys = int'(c.y_start);
		xe = int'(c.x_end);
		ye = int'(c.y_end);
		case (c.operation)
			OP_SET_PEN: pen_copy = c.color_in[COLOR_BITS-1:0];
			OP_CLEAR: begin
				pen_copy = '0;
				foreach (frame_copy[i]) frame_copy[i] = '0;
			end
			OP_PIXEL: plot(xs, ys);
			OP_HLINE: plot_row(xs, ys, xe);
			OP_VLINE: plot_col(xs, ys, ye);
			OP_RECT: begin
				plot_row(xs, ys, xe);
				plot_row(xs, ye, xe);
				plot_col(xs, ys, ye);
				plot_col(xe, ys, ye);
				plot(xe, ye);
			end
			OP_READ: begin
				if (xs >= FRAME_WIDTH || ys >= FRAME_HEIGHT) begin
					stray_pixel = 1'b1;
				end else begin
					r.read_color = frame_copy[ys * FRAME_WIDTH + xs];
				end
			end
			default: ;
		endcase
		r.out_of_range = stray_pixel;
		return r;
	endfunction

	// command sender with random idle bursts
	int send_gap = 0;
	logic send_next;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			send_gap = 0;
		end else begin
			send_next = cmd_valid;
			if (cmd_valid && cmd_ready) begin
				results_due.push_back(apply_command(cmd));
				send_next = 1'b0;
			end
			if (!send_next) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (cmd_backlog.size() != 0) begin
					if (!steady && $urandom_range(0, 7) == 0) begin
						send_gap = $urandom_range(0, 14);
					end else begin
						cmd <= cmd_backlog.pop_front();
						send_next = 1'b1;
					end
				end
			end
			cmd_valid <= send_next;
		end
	end

	// result receiver: checks each item, stalls at random, one long hold-off
	int stall_left = 0;
	bit hold_taken = 1'b0;
	logic take_next;
	fbrd_res_t due;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (results_due.size() == 0) begin
					$error("result item with nothing expected: read_color %0d out_of_range %0d",
						res.read_color, res.out_of_range);
					mismatch_count++;
				end else begin
					due = results_due.pop_front();
					if (res.read_color !== due.read_color) begin
						$error("read_color expected %0d actual %0d", due.read_color,
							res.read_color);
						mismatch_count++;
					end
					if (res.out_of_range !== due.out_of_range) begin
						$error("out_of_range expected %0d actual %0d", due.out_of_range,
							res.out_of_range);
						mismatch_count++;
					end
				end
			end
			take_next = 1'b1;
			if (hold_go && !hold_taken) begin
				hold_taken = 1'b1;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				take_next = 1'b0;
			end else if (!steady && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 14);
				take_next = 1'b0;
			end
			res_ready <= take_next;
		end
	end

	// watchdog on cycles with no item moving on either side
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("framebuffer_line_rect_drawer_top test failed");
				$finish;
			end
		end
	end

	function automatic fbrd_cmd_t cmd_item(logic [2:0] op, int xs, int ys, int xe, int ye,
			int col);
		fbrd_cmd_t c;
		c.operation = op;
		c.x_start = 6'(xs);
		c.y_start = 5'(ys);
		c.x_end = 7'(xe);
		c.y_end = 6'(ye);
		c.color_in = 4'(col);
		return c;
	endfunction

	// far end: mostly a short span past the start, sometimes empty, sometimes anywhere
	function automatic int pick_end(int start, int top, int span);
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, top);
			1: return $urandom_range(0, start);
			default: return start + $urandom_range(1, span);
		endcase
	endfunction

	// random commands of all codes, with read-back of recently drawn points
	task automatic queue_random(int count);
		fbrd_cmd_t c;
		int pick;
		int xs;
		int ys;
		int last_x;
		int last_y;
		last_x = 0;
		last_y = 0;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			xs = $urandom_range(0, FRAME_WIDTH - 1);
			ys = $urandom_range(0, FRAME_HEIGHT - 1);
			c = cmd_item(OP_READ, xs, ys, pick_end(xs, 127, 20), pick_end(ys, 63, 12),
				$urandom_range(0, 15));
			if (pick < 1) c.operation = OP_CLEAR;
			else if (pick < 11) c.operation = OP_SET_PEN;
			else if (pick < 24) c.operation = OP_PIXEL;
			else if (pick < 38) c.operation = OP_HLINE;
			else if (pick < 52) c.operation = OP_VLINE;
			else if (pick < 62) c.operation = OP_RECT;
			else if (pick < 97) c.operation = OP_READ;
			else c.operation = OP_UNUSED;
			if (c.operation == OP_READ && $urandom_range(0, 1) == 1) begin
				c.x_start = 6'(last_x);
				c.y_start = 5'(last_y);
			end
			if (c.operation inside {OP_PIXEL, OP_HLINE, OP_VLINE, OP_RECT}) begin
				last_x = xs;
				last_y = ys;
			end
			cmd_backlog.push_back(c);
		end
	endtask

	task automatic wait_drained();
		while (cmd_backlog.size() != 0 || cmd_valid || results_due.size() != 0)
			@(negedge clk);
	endtask

	// stimulus sequence and final verdict
	initial begin
		foreach (frame_copy[i]) frame_copy[i] = '0;
		pen_copy = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: field extremes, every command, empty and clipped shapes
		cmd_backlog.push_back(cmd_item(OP_READ, 5, 5, 0, 0, 0));
		cmd_backlog.push_back(cmd_item(OP_SET_PEN, 0, 0, 0, 0, 15));
		cmd_backlog.push_back(cmd_item(OP_PIXEL, 0, 0, 0, 0, 0));
		cmd_backlog.push_back(cmd_item(OP_PIXEL, 63, 31, 127, 63, 0));
		cmd_backlog.push_back(cmd_item(OP_READ, 0, 0, 0, 0, 0));
		cmd_backlog.push_back(cmd_item(OP_READ, 63, 31, 0, 0, 0));
		cmd_backlog.push_back(cmd_item(OP_SET_PEN, 0, 0, 0, 0, 5));
		cmd_backlog.push_back(cmd_item(OP_HLINE, 0, 0, 64, 0, 0));
		cmd_backlog.push_back(cmd_item(OP_HLINE, 60, 1, 127, 0, 0));
		cmd_backlog.push_back(cmd_item(OP_HLINE, 10, 2, 10, 0, 0));
		cmd_backlog.push_back(cmd_item(OP_HLINE, 20, 2, 3, 0, 0));
		cmd_backlog.push_back(cmd_item(OP_VLINE, 0, 0, 0, 32, 0));
		cmd_backlog.push_back(cmd_item(OP_VLINE, 63, 30, 0, 63, 0));
		cmd_backlog.push_back(cmd_item(OP_VLINE, 7, 5, 0, 5, 0));
		cmd_backlog.push_back(cmd_item(OP_SET_PEN, 0, 0, 0, 0, 10));
		cmd_backlog.push_back(cmd_item(OP_RECT, 2, 3, 10, 8, 0));
		cmd_backlog.push_back(cmd_item(OP_READ, 10, 8, 0, 0, 0));
		cmd_backlog.push_back(cmd_item(OP_READ, 2, 8, 0, 0, 0));
		cmd_backlog.push_back(cmd_item(OP_RECT, 50, 20, 64, 32, 0));
		cmd_backlog.push_back(cmd_item(OP_RECT, 0, 0, 127, 63, 0));
		// inverted corners: only the far corner pixel is drawn
		cmd_backlog.push_back(cmd_item(OP_RECT, 40, 20, 30, 10, 0));
		cmd_backlog.push_back(cmd_item(OP_UNUSED, 63, 31, 127, 63, 15));
		cmd_backlog.push_back(cmd_item(OP_CLEAR, 0, 0, 0, 0, 0));
		cmd_backlog.push_back(cmd_item(OP_READ, 63, 31, 0, 0, 0));
		cmd_backlog.push_back(cmd_item(OP_PIXEL, 30, 15, 0, 0, 0));
		wait_drained();

		queue_random(300);
		while (cmd_backlog.size() != 0) @(negedge clk);

		// receiver holds off while items keep coming, then the sender waits it out
		hold_go = 1'b1;
		queue_random(100);
		wait_drained();

		queue_random(170);
		while (cmd_backlog.size() != 0) @(negedge clk);

		// last stretch at full rate on both sides
		steady = 1'b1;
		queue_random(80);
		wait_drained();
		repeat (20) @(negedge clk);

		if (mismatch_count == 0 && results_due.size() == 0) begin
			$display("framebuffer_line_rect_drawer_top test passed");
		end else begin
			$display("framebuffer_line_rect_drawer_top test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/fbrd_pkg.sv
rtl/core/fbrd_frame_mem.sv
rtl/core/framebuffer_line_rect_drawer_top.sv
tb/sv/framebuffer_line_rect_drawer_top_tb.sv
